@@ rtl/core/nws_pkg.sv @@
// Shared constants, codes and controller/datapath interface types for the waypoint search.
package nws_pkg;

  // Table and coordinate sizes
  localparam int MAX_POINTS  = 16;
  localparam int COORD_WIDTH = 24;
  localparam int IDX_W       = $clog2(MAX_POINTS);
  localparam int CNT_W       = $clog2(MAX_POINTS + 1);
  localparam int PCOUNT_W    = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = COORD_WIDTH;

  // Magnitude of a coordinate difference and an exact squared distance
  localparam int MAG_W  = COORD_WIDTH + 1;
  localparam int DIST_W = 2 * MAG_W;

  // Input item modes
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POINT_COUNT = 2'd0,
    CFG_BASE_X      = 2'd1,
    CFG_BASE_Y      = 2'd2
  } cfg_reg_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_BASE,
    ST_BPOS,
    ST_FINAL,
    ST_FETCH,
    ST_DONE
  } state_t;

  // What a distance pipeline entry measures
  typedef enum logic [1:0] {
    KIND_SCAN,   // stored waypoint against current position
    KIND_PT,     // nearest waypoint against base point
    KIND_POS     // current position against base point
  } kind_t;

  // Table read address source
  typedef enum logic [1:0] {
    ADDR_SCAN,
    ADDR_BEST,
    ADDR_CHOSEN
  } addr_sel_t;

  typedef struct packed {
    logic             load_wr;    // write a waypoint entry
    logic             capture;    // latch query position and point count
    logic             rd_en;
    addr_sel_t        addr_sel;
    logic [IDX_W-1:0] scan_addr;
    logic             issue;      // launch an entry into the distance pipeline
    kind_t            kind;
    logic             out_load;   // fill the result register
  } dp_cmd_t;

  typedef struct packed {
    logic             pipe_busy;
    logic             out_busy;
    logic [CNT_W-1:0] count;
  } dp_status_t;

endpackage

@@ rtl/core/nws_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module nws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, held while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/nws_ctrl.sv @@
// Sequencer for loads, the table scan, the base comparison and result hand-off.
module nws_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                mode,
  output logic                in_ready,
  input  nws_pkg::dp_status_t st,
  output nws_pkg::dp_cmd_t    cmd
);
  import nws_pkg::*;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             accept;
  logic             scan_last;

  assign accept    = in_valid && in_ready;
  assign scan_last = (cnt + CNT_W'(1)) == st.count;

  // State and scan counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && mode == MODE_QUERY) begin
          state_next = ST_SCAN;
          cnt_next   = '0;
        end
      end
      ST_SCAN: begin
        cnt_next = cnt + CNT_W'(1);
        if (scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!st.pipe_busy) begin
          state_next = ST_BASE;
        end
      end
      ST_BASE:  state_next = ST_BPOS;
      ST_BPOS:  state_next = ST_FINAL;
      ST_FINAL: begin
        if (!st.pipe_busy) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: state_next = ST_DONE;
      ST_DONE: begin
        if (!st.out_busy) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.addr_sel  = ADDR_SCAN;
    cmd.kind      = KIND_SCAN;
    cmd.scan_addr = cnt[IDX_W-1:0];
    unique case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_wr = accept && mode == MODE_LOAD;
        cmd.capture = accept && mode == MODE_QUERY;
      end
      ST_SCAN: begin
        cmd.rd_en = 1'b1;
        cmd.issue = 1'b1;
      end
      ST_BASE: begin
        cmd.rd_en    = 1'b1;
        cmd.addr_sel = ADDR_BEST;
        cmd.issue    = 1'b1;
        cmd.kind     = KIND_PT;
      end
      ST_BPOS: begin
        cmd.issue = 1'b1;
        cmd.kind  = KIND_POS;
      end
      ST_FETCH: begin
        cmd.rd_en    = 1'b1;
        cmd.addr_sel = ADDR_CHOSEN;
      end
      ST_DONE:  cmd.out_load = !st.out_busy;
      default: ;
    endcase
  end

endmodule

@@ rtl/core/nws_dp.sv @@
// Datapath: waypoint table, configuration registers, distance pipeline and result register.
module nws_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  nws_pkg::dp_cmd_t                    cmd,
  output nws_pkg::dp_status_t                 st,
  input  logic                                cfg_valid,
  input  logic [nws_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [nws_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [nws_pkg::IDX_W-1:0]           point_index,
  input  logic signed [nws_pkg::COORD_WIDTH-1:0] pos_x,
  input  logic signed [nws_pkg::COORD_WIDTH-1:0] pos_y,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [nws_pkg::IDX_W-1:0]           nearest_index,
  output logic [nws_pkg::IDX_W-1:0]           next_index,
  output logic signed [nws_pkg::COORD_WIDTH-1:0] next_x,
  output logic signed [nws_pkg::COORD_WIDTH-1:0] next_y
);
  import nws_pkg::*;

  localparam int CW = COORD_WIDTH;

  // Configuration and query registers
  logic [PCOUNT_W-1:0]  point_count;
  logic signed [CW-1:0] base_x, base_y;
  logic signed [CW-1:0] cur_x, cur_y;
  logic [CNT_W-1:0]     count, count_sat;

  // Table
  logic [IDX_W-1:0]     rd_addr;
  logic [2*CW-1:0]      ram_q;
  logic signed [CW-1:0] ram_x, ram_y;

  // Distance pipeline
  logic                 v0, v1, v2;
  kind_t                kind0, kind1, kind2;
  logic [IDX_W-1:0]     idx0, idx1, idx2;
  logic signed [CW-1:0] ax, ay, bx, by;
  logic signed [MAG_W-1:0] dx, dy;
  logic [MAG_W-1:0]     mag_x_c, mag_y_c, mag_x, mag_y;
  logic [DIST_W-1:0]    sqx_c, sqy_c, sq_x, sq_y, dist_sum;

  // Search results
  logic [IDX_W-1:0]     best, chosen;
  logic [DIST_W-1:0]    best_dist, dist_pt, dist_pos;
  logic                 advance;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= PCOUNT_W'(10);
      base_x      <= '0;
      base_y      <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_POINT_COUNT: point_count <= cfg_data[PCOUNT_W-1:0];
        CFG_BASE_X:      base_x      <= cfg_data[CW-1:0];
        CFG_BASE_Y:      base_y      <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  // Count in use: zero counts as one, large values clamp to the table size
  always_comb begin
    if (point_count == '0) begin
      count_sat = CNT_W'(1);
    end else if (int'(point_count) > MAX_POINTS) begin
      count_sat = CNT_W'(MAX_POINTS);
    end else begin
      count_sat = CNT_W'(point_count);
    end
  end

  // Query capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_x <= pos_x;
      cur_y <= pos_y;
      count <= count_sat;
    end
  end

  // Table read address
  always_comb begin
    case (cmd.addr_sel)
      ADDR_BEST:   rd_addr = best;
      ADDR_CHOSEN: rd_addr = chosen;
      default:     rd_addr = cmd.scan_addr;
    endcase
  end

  nws_ram #(
    .WIDTH (2 * CW),
    .DEPTH (MAX_POINTS)
  ) u_table (
    .clk     (clk),
    .wr_en   (cmd.load_wr),
    .wr_addr (point_index),
    .wr_data ({pos_x, pos_y}),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  assign ram_x = ram_q[2*CW-1:CW];
  assign ram_y = ram_q[CW-1:0];

  // Pipeline control: stage 0 lines up with the table read data
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v0 <= cmd.issue;
      v1 <= v0;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    kind0 <= cmd.kind;
    idx0  <= rd_addr;
    kind1 <= kind0;
    idx1  <= idx0;
    kind2 <= kind1;
    idx2  <= idx1;
  end

  // Operand selection per entry kind
  always_comb begin
    case (kind0)
      KIND_PT: begin
        ax = ram_x;  ay = ram_y;
        bx = base_x; by = base_y;
      end
      KIND_POS: begin
        ax = cur_x;  ay = cur_y;
        bx = base_x; by = base_y;
      end
      default: begin
        ax = ram_x;  ay = ram_y;
        bx = cur_x;  by = cur_y;
      end
    endcase
  end

  // Stage 1: absolute differences
  assign dx      = MAG_W'(ax) - MAG_W'(bx);
  assign dy      = MAG_W'(ay) - MAG_W'(by);
  assign mag_x_c = dx[MAG_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
  assign mag_y_c = dy[MAG_W-1] ? MAG_W'(-dy) : MAG_W'(dy);

  always_ff @(posedge clk) begin
    mag_x <= mag_x_c;
    mag_y <= mag_y_c;
  end

  // Stage 2: squares
  assign sqx_c = mag_x * mag_x;
  assign sqy_c = mag_y * mag_y;

  always_ff @(posedge clk) begin
    sq_x <= sqx_c;
    sq_y <= sqy_c;
  end

  // Stage 3: sum and keep; a later entry wins a tie
  assign dist_sum = sq_x + sq_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      best <= '0;
    end else if (v2) begin
      case (kind2)
        KIND_PT:  dist_pt  <= dist_sum;
        KIND_POS: dist_pos <= dist_sum;
        default: begin
          if (idx2 == '0 || dist_sum <= best_dist) begin
            best      <= idx2;
            best_dist <= dist_sum;
          end
        end
      endcase
    end
  end

  // Advance one entry when the nearest point is no closer to base than we are and is not the last entry in use
  assign advance = (dist_pt >= dist_pos) && ((CNT_W'(best) + CNT_W'(1)) < count);
  assign chosen  = advance ? best + IDX_W'(1) : best;

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      nearest_index <= best;
      next_index    <= chosen;
      next_x        <= ram_x;
      next_y        <= ram_y;
    end
  end

  assign st.pipe_busy = v0 || v1 || v2;
  assign st.out_busy  = out_valid && !out_ready;
  assign st.count     = count;

endmodule

@@ rtl/core/next_waypoint_search.sv @@
// Top level of the next-waypoint search: nearest stored waypoint with a one-step advance.
// A load item is written into the table; the next item is accepted in the cycle after it.
// A query scans N entries (point_count, zero taken as one, capped at 16), one read per
// cycle, through a three-stage distance pipeline, then measures base distances: its
// result is loaded after the pipeline drains and the chosen entry is read; the next item
// is taken in the cycle after the load, or later still while an earlier result waits.
// Synchronous reset sets point_count to 10 and the base point to zero; table is unwritten.
module next_waypoint_search (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   mode,
  input  logic [nws_pkg::IDX_W-1:0]              point_index,
  input  logic signed [nws_pkg::COORD_WIDTH-1:0] pos_x,
  input  logic signed [nws_pkg::COORD_WIDTH-1:0] pos_y,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [nws_pkg::IDX_W-1:0]              nearest_index,
  output logic [nws_pkg::IDX_W-1:0]              next_index,
  output logic signed [nws_pkg::COORD_WIDTH-1:0] next_x,
  output logic signed [nws_pkg::COORD_WIDTH-1:0] next_y,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [nws_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [nws_pkg::CFG_DATA_W-1:0]         cfg_data
);
  import nws_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;

  // Registers are always writable
  assign cfg_ready = 1'b1;

  nws_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .mode     (mode),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  nws_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .point_index   (point_index),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .nearest_index (nearest_index),
    .next_index    (next_index),
    .next_x        (next_x),
    .next_y        (next_y)
  );

  // Nothing is in flight in the distance pipeline while items are taken
  a_idle_pipe: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !st.pipe_busy)
    else $error("distance pipeline busy while accepting items");

  // A query closes the input until its search is over
  a_query_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && mode == MODE_QUERY) |=> !in_ready)
    else $error("input still open after a query item");

  // The chosen entry is the nearest one or the one after it
  a_advance_one: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (next_index == nearest_index ||
                   next_index == nearest_index + IDX_W'(1)))
    else $error("chosen index is not nearest or nearest plus one");

  // A new result never overwrites one still waiting to be taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(out_valid && !out_ready))
    else $error("result register loaded while occupied");

endmodule
